@@ rtl/xsad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xsad_pkg;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OVER_REM  = 2'd2;
  localparam logic [1:0] ST_OVER_MAX  = 2'd3;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] idx;
    logic [7:0]  data;
    logic        send;
    logic [1:0]  status;
    logic [32:0] pos;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/xsad_res_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xsad_res_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    push_n_i,
  input  wire xsad_pkg::res_t push0_i,
  input  wire xsad_pkg::res_t push1_i,
  input  wire logic          pop_i,
  output xsad_pkg::res_t     head_o,
  output logic               valid_o,
  output logic [xsad_pkg::ResCntW-1:0] count_o
);
  import xsad_pkg::*;

  res_t                mem_q [ResDepth];
  logic [ResPtrW-1:0]  wp_q, rp_q, wp1;
  logic [ResCntW-1:0]  cnt_q;
  logic                pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign wp1     = wp_q + ResPtrW'(1);
  assign head_o  = mem_q[rp_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + ResPtrW'(push_n_i);
      if (pop) begin
        rp_q <= rp_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + ResCntW'(push_n_i) - ResCntW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd0 && !pop_i) |=> $stable(cnt_q))
    else $error("result queue count moved without push or pop");

endmodule

`default_nettype wire

@@ rtl/xdr_string_array_deframer_top.sv @@
// Throughput: one request per cycle while each request yields at most one result, the
// output is not stalled and the result queue holds no more than two entries; requests
// yielding two results drain at one result per cycle through a 4-entry queue.
// Request input is held in one register; decode state advances when it leaves it.
// Reset: asynchronous, active low; decoder idle, registers at their defaults
// (max_string_len all ones, others zero), result queue empty.
`timescale 1ns / 1ps
`default_nettype none

module xdr_string_array_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [23:0]      string_index_o,
  output logic [7:0]       out_byte_o,
  output logic             string_end_o,
  output logic [1:0]       status_o,
  output logic [32:0]      end_position_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import xsad_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD,
    PH_DONE
  } phase_e;

  logic [31:0] start_q, region_q, maxlen_q;
  logic [23:0] count_q;

  logic        v_q, v_d;
  logic        req_q;
  logic [7:0]  byte_q;
  logic        proc, in_acc;

  phase_e      ph_q, ph_d;
  logic [31:0] hs_q, hs_d;
  logic [1:0]  hbs_q, hbs_d;
  logic [31:0] pl_q, pl_d;
  logic [1:0]  pad_q, pad_d;
  logic [32:0] bc_q, bc_d;
  logic [23:0] sd_q, sd_d;

  res_t                res_d [2];
  logic [1:0]          n_d;
  res_t                head;
  logic [ResCntW-1:0]  q_cnt;

  function automatic res_t mk_status(logic [1:0] st, logic [23:0] idx, logic [31:0] start,
                                     logic [32:0] bc);
    res_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.idx    = idx;
    r.status = st;
    r.pos    = (st == ST_COMPLETE) ? ({1'b0, start} + bc) : 33'd0;
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      region_q <= '0;
      maxlen_q <= '1;
      count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_START:  start_q  <= cfg_data_i;
        REG_LENGTH: region_q <= cfg_data_i;
        REG_MAXLEN: maxlen_q <= cfg_data_i;
        REG_COUNT:  count_q  <= cfg_data_i[23:0];
        default:    start_q  <= start_q;
      endcase
    end
  end

  assign proc       = v_q && (q_cnt <= ResCntW'(ResDepth - 2));
  assign in_stall_o = v_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign v_d        = in_acc ? 1'b1 : (proc ? 1'b0 : v_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_type_i;
      byte_q <= data_byte_i;
    end
  end

  always_comb begin
    logic [32:0] bc_v;
    logic [32:0] rem_v;
    logic [23:0] sd_v;
    logic [31:0] e_v;
    logic [1:0]  p_v;
    logic        ap;
    logic        fin;
    logic        hdr;
    res_t        r;

    ph_d  = ph_q;
    hs_d  = hs_q;
    hbs_d = hbs_q;
    pl_d  = pl_q;
    pad_d = pad_q;
    bc_v  = bc_q;
    rem_v = '0;
    sd_v  = sd_q;
    e_v   = '0;
    p_v   = pad_q;
    ap    = 1'b0;
    fin   = 1'b0;
    hdr   = 1'b0;
    r     = '0;
    n_d   = 2'd0;
    res_d[0] = '0;
    res_d[1] = '0;

    if (proc) begin
      if (req_q) begin
        hs_d  = '0;
        hbs_d = '0;
        pl_d  = '0;
        pad_d = '0;
        bc_v  = '0;
        sd_v  = '0;
        hdr   = 1'b1;
      end else begin
        case (ph_q)
          PH_HEADER: begin
            hs_d = {hs_q[23:0], byte_q};
            bc_v = bc_q + 33'd1;
            if (hbs_q != 2'd3) begin
              hbs_d = hbs_q + 2'd1;
            end else begin
              hbs_d = '0;
              e_v   = hs_d;
              rem_v = (bc_v > {1'b0, region_q}) ? 33'd0 : ({1'b0, region_q} - bc_v);
              if ({1'b0, e_v} > rem_v) begin
                res_d[0] = mk_status(ST_OVER_REM, sd_v, start_q, bc_v);
                n_d      = 2'd1;
                ph_d     = PH_DONE;
              end else if (e_v > maxlen_q) begin
                res_d[0] = mk_status(ST_OVER_MAX, sd_v, start_q, bc_v);
                n_d      = 2'd1;
                ph_d     = PH_DONE;
              end else if (e_v == 32'd0) begin
                pad_d    = '0;
                r.kind   = KIND_EMPTY;
                r.idx    = sd_v;
                res_d[0] = r;
                n_d      = 2'd1;
                p_v      = 2'd0;
                ap       = 1'b1;
              end else begin
                pl_d  = e_v;
                pad_d = 2'(~e_v[1:0] + 2'd1);
                ph_d  = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            bc_v     = bc_q + 33'd1;
            pl_d     = pl_q - 32'd1;
            r.kind   = KIND_BYTE;
            r.idx    = sd_v;
            r.data   = byte_q;
            r.send   = (pl_q == 32'd1);
            res_d[0] = r;
            n_d      = 2'd1;
            if (pl_q == 32'd1) begin
              p_v = pad_q;
              ap  = 1'b1;
            end
          end
          PH_PAD: begin
            bc_v  = bc_q + 33'd1;
            pad_d = pad_q - 2'd1;
            if (pad_q == 2'd1) begin
              fin = 1'b1;
            end
          end
          default: begin
            ph_d = ph_q;
          end
        endcase
      end

      if (ap) begin
        rem_v = (bc_v > {1'b0, region_q}) ? 33'd0 : ({1'b0, region_q} - bc_v);
        if (p_v == 2'd0) begin
          fin = 1'b1;
        end else if ({31'd0, p_v} <= rem_v) begin
          ph_d = PH_PAD;
        end else begin
          bc_v  = bc_v + {31'd0, p_v};
          pad_d = '0;
          fin   = 1'b1;
        end
      end

      if (fin) begin
        sd_v = sd_v + 24'd1;
        hdr  = 1'b1;
      end

      if (hdr) begin
        if (sd_v >= count_q) begin
          res_d[n_d[0]] = mk_status(ST_COMPLETE, sd_v, start_q, bc_v);
          n_d           = n_d + 2'd1;
          ph_d          = PH_DONE;
        end else if ((bc_v + 33'd4) > {1'b0, region_q}) begin
          res_d[n_d[0]] = mk_status(ST_EXHAUSTED, sd_v, start_q, bc_v);
          n_d           = n_d + 2'd1;
          ph_d          = PH_DONE;
        end else begin
          ph_d  = PH_HEADER;
          hs_d  = '0;
          hbs_d = '0;
        end
      end
    end

    bc_d = bc_v;
    sd_d = sd_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      ph_q  <= PH_IDLE;
      hs_q  <= '0;
      hbs_q <= '0;
      pl_q  <= '0;
      pad_q <= '0;
      bc_q  <= '0;
      sd_q  <= '0;
    end else begin
      v_q   <= v_d;
      ph_q  <= ph_d;
      hs_q  <= hs_d;
      hbs_q <= hbs_d;
      pl_q  <= pl_d;
      pad_q <= pad_d;
      bc_q  <= bc_d;
      sd_q  <= sd_d;
    end
  end

  xsad_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (n_d),
    .push0_i  (res_d[0]),
    .push1_i  (res_d[1]),
    .pop_i    (out_valid_o && !out_stall_i),
    .head_o   (head),
    .valid_o  (out_valid_o),
    .count_o  (q_cnt)
  );

  assign out_kind_o     = head.kind;
  assign string_index_o = head.idx;
  assign out_byte_o     = head.data;
  assign string_end_o   = head.send;
  assign status_o       = head.status;
  assign end_position_o = head.pos;

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && req_q) |=> (ph_q == PH_HEADER || ph_q == PH_DONE))
    else $error("start request did not begin decoding");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_PAYLOAD) |-> (pl_q != 32'd0))
    else $error("payload phase with no bytes left");

  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_PAD) |-> (pad_q != 2'd0))
    else $error("pad phase with no padding left");

  a_hdr_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PH_HEADER) |-> (hbs_q == 2'd0))
    else $error("header byte count left set outside header phase");

endmodule

`default_nettype wire
